// ----- sv/cswf_pkg.sv -----
// Package for the counting semaphore with a FIFO wait queue.
// Holds the request/result types, command and event codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cswf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TID_W           = 8;
    localparam int COUNT_W         = 16;
    localparam int INIT_W          = 15;

    localparam logic [1:0] CMD_DOWN    = 2'd0;
    localparam logic [1:0] CMD_UP      = 2'd1;
    localparam logic [1:0] CMD_DESTROY = 2'd2;

    localparam logic [2:0] EV_GRANTED  = 3'd0;
    localparam logic [2:0] EV_BLOCKED  = 3'd1;
    localparam logic [2:0] EV_WOKEN    = 3'd2;
    localparam logic [2:0] EV_NONE     = 3'd3;
    localparam logic [2:0] EV_QFULL    = 3'd4;
    localparam logic [2:0] EV_RELEASED = 3'd5;

    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TID_W-1:0] task_id;
    } t_sem_req;

    typedef struct packed {
        logic [2:0]                 event_res;
        logic [TID_W-1:0]           woken_task;
        logic signed [COUNT_W-1:0]  count_now;
        logic                       last;
    } t_sem_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_DRAIN
    } t_state_e;

endpackage

`default_nettype wire

// ----- sv/cswf_wait_mem.sv -----
// Wait-queue storage: single write port, single read port, registered read data.
// Depends on cswf_pkg for the task id width.
`timescale 1ns / 1ps
`default_nettype none

module cswf_wait_mem #(
    parameter int QUEUE_DEPTH = cswf_pkg::QUEUE_DEPTH_DEF,
    parameter int PTR_W       = 4
) (
    input  wire                        i_clk,
    input  wire                        i_wr_en,
    input  wire  [PTR_W-1:0]           i_wr_addr,
    input  wire  [cswf_pkg::TID_W-1:0] i_wr_data,
    input  wire                        i_rd_en,
    input  wire  [PTR_W-1:0]           i_rd_addr,
    output logic [cswf_pkg::TID_W-1:0] o_rd_data
);
    import cswf_pkg::*;

    logic [TID_W-1:0] r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/counting_semaphore_wait_fifo_unit.sv -----
// Counting semaphore with a FIFO wait queue: count register, sequencer, wait-queue memory.
// Depends on cswf_pkg and cswf_wait_mem.
//
// A command is taken when i_start is high and o_busy is low. Down, a non-waking up and a
// destroy with an empty queue keep the block idle, and the next command can follow at once.
// An up that wakes a waiter goes busy in ST_UP_RD for the registered wait-queue read.
// A destroy with waiters goes busy in ST_DRAIN: the drain reads one queue entry per cycle and
// gives one released result per cycle, the final one marked by last. Each result is shown on
// o_res for a single cycle with o_res_valid high; the receiver cannot stall the block.
// i_cfg_data loads the initial count, taken at reset (as 0) and on every destroy.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_wait_fifo_unit #(
    parameter int QUEUE_DEPTH = cswf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire  cswf_pkg::t_sem_req    i_req,
    output logic                        o_busy,
    output logic                        o_res_valid,
    output cswf_pkg::t_sem_res          o_res,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [cswf_pkg::INIT_W-1:0] i_cfg_data
);
    import cswf_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [WAIT_W-1:0] WAIT_FULL = WAIT_W'(QUEUE_DEPTH);

    t_state_e                   r_state, n_state;
    logic signed [COUNT_W-1:0]  r_count, n_count;
    logic [INIT_W-1:0]          r_init;
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [WAIT_W-1:0]          r_waiting, n_waiting;
    logic                       r_res_valid, n_res_valid;
    t_sem_res                   r_res, n_res;

    logic                       w_accept;
    logic signed [COUNT_W-1:0]  w_dec, w_inc, w_init;
    logic                       w_full, w_empty, w_up_wake;
    logic [PTR_W-1:0]           w_head_nx, w_tail_nx;
    logic                       w_wr_en, w_rd_en;
    logic [TID_W-1:0]           w_rd_data;

    assign o_busy      = (r_state != ST_IDLE);
    // no initial-count write in the cycle a command is taken
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign w_accept  = i_start && (r_state == ST_IDLE);
    assign w_dec     = (r_count == COUNT_MIN) ? r_count : r_count - 1'b1;
    assign w_inc     = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
    assign w_init    = COUNT_W'({1'b0, r_init});
    assign w_full    = (r_waiting == WAIT_FULL);
    assign w_empty   = (r_waiting == '0);
    // up wakes the head waiter only while the count stays at or below zero
    assign w_up_wake = !w_empty && (w_inc[COUNT_W-1] || (w_inc == '0));
    assign w_head_nx = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;

    // A down writes the tail and any later read of that entry comes in a later command or
    // drain step, so the read and write ports never touch the same entry in one cycle.
    cswf_wait_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_wait_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_req.task_id),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.cmd == CMD_UP && w_up_wake) begin
                        n_state = ST_UP_RD;
                    end else if (i_req.cmd == CMD_DESTROY && !w_empty) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_UP_RD: n_state = ST_IDLE;
            ST_DRAIN: begin
                if (w_empty) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_waiting   = r_waiting;
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res.woken_task = '0;
                    n_res.last       = 1'b1;
                    unique case (i_req.cmd)
                        CMD_DOWN: begin
                            n_res_valid = 1'b1;
                            if (w_full) begin
                                n_res.event_res = EV_QFULL;
                                n_res.count_now = r_count;
                            end else begin
                                n_count         = w_dec;
                                n_res.count_now = w_dec;
                                if (w_dec[COUNT_W-1]) begin
                                    w_wr_en         = 1'b1;
                                    n_tail          = w_tail_nx;
                                    n_waiting       = r_waiting + 1'b1;
                                    n_res.event_res = EV_BLOCKED;
                                end else begin
                                    n_res.event_res = EV_GRANTED;
                                end
                            end
                        end
                        CMD_UP: begin
                            n_count = w_inc;
                            if (w_up_wake) begin
                                w_rd_en   = 1'b1;
                                n_head    = w_head_nx;
                                n_waiting = r_waiting - 1'b1;
                            end else begin
                                n_res_valid     = 1'b1;
                                n_res.event_res = EV_NONE;
                                n_res.count_now = w_inc;
                            end
                        end
                        CMD_DESTROY: begin
                            n_count = w_init;
                            if (w_empty) begin
                                n_res_valid     = 1'b1;
                                n_res.event_res = EV_NONE;
                                n_res.count_now = w_init;
                            end else begin
                                w_rd_en   = 1'b1;
                                n_head    = w_head_nx;
                                n_waiting = r_waiting - 1'b1;
                            end
                        end
                        default: begin
                            // unused command: no result, no state change
                        end
                    endcase
                end
            end
            ST_UP_RD: begin
                n_res_valid      = 1'b1;
                n_res.event_res  = EV_WOKEN;
                n_res.woken_task = w_rd_data;
                n_res.count_now  = r_count;
                n_res.last       = 1'b1;
            end
            ST_DRAIN: begin
                n_res_valid      = 1'b1;
                n_res.event_res  = EV_RELEASED;
                n_res.woken_task = w_rd_data;
                n_res.count_now  = r_count;
                n_res.last       = w_empty;
                if (w_empty) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    w_rd_en   = 1'b1;
                    n_head    = w_head_nx;
                    n_waiting = r_waiting - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_init      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_waiting   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_waiting   <= n_waiting;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_init <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting <= WAIT_FULL)
        else $error("wait count exceeds queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_waiting == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_drain_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN || r_state == ST_UP_RD) |=> o_res_valid)
        else $error("read cycle produced no result");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> (r_state == ST_DRAIN))
        else $error("non-final result outside a drain");

endmodule

`default_nettype wire
